### sv/cmc_pkg.sv
// Shared types, codes and register reset values for the calibration mode controller.
`default_nettype none
package cmc_pkg;

	localparam int unsigned TIME_W = 32;

	// Item kinds carried in s_tuser
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;
	localparam logic [1:0] KIND_KEEP  = 2'd3;

	// Mode events, also used as pending codes
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_ENTER = 2'd1;
	localparam logic [1:0] EV_EXIT  = 2'd2;

	// Calibration origins
	localparam logic [1:0] ORG_NONE = 2'd0;
	localparam logic [1:0] ORG_HW   = 2'd1;
	localparam logic [1:0] ORG_SW   = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_SCAN     = 2'd2;
	localparam logic [1:0] REG_BUTTON   = 2'd3;

	localparam logic [15:0] DEBOUNCE_RST = 16'd100;
	localparam logic [15:0] TIMEOUT_RST  = 16'd1500;
	localparam logic [7:0]  SCAN_RST     = 8'd10;
	localparam logic        BUTTON_RST   = 1'b1;

	typedef struct packed {
		logic [15:0] debounce_ticks;
		logic [15:0] timeout_ticks;
		logic [7:0]  scan_interval_ticks;
		logic        button_present;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [TIME_W-1:0] now_time;
		logic              button_active;
	} item_t;

	typedef struct packed {
		logic [1:0] mode_event;
		logic       in_calibration;
		logic [1:0] cal_origin;
	} result_t;

endpackage
`default_nettype wire

### sv/calibration_mode_controller_unit.sv
// Top level of the calibration mode controller: input register, update core, result register.
// Each accepted beat is one event (tick, start request, stop request or keepalive) and gives
// exactly one result beat. A beat is held in the input register while the core updates the
// mode state and loads the result register, which then presents the result on m_tvalid and
// m_tdata. One beat is taken every cycle while the result side is not stalled; the limit is
// the state update in the core, which must finish before the next event can use its outcome.
// A result waiting on m_tready holds any beat in the input register, which then stops
// accepting until the result is taken. Configuration registers should be written only while
// no beat is in flight.
`default_nettype none
module calibration_mode_controller_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // [31:0] now_time, [32] button_active, rest zero
	input  wire logic [1:0]  s_tuser,  // [1:0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // [1:0] mode_event, [2] in_calibration, [4:3] cal_origin
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import cmc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance, accept;
	result_t res, res_q;
	logic    out_valid_q;

	cmc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cmc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res)
	);

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.kind          <= s_tuser;
			item_s1.now_time      <= s_tdata[31:0];
			item_s1.button_active <= s_tdata[32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, res_q.cal_origin, res_q.in_calibration, res_q.mode_event};

	// A result never reports an origin outside calibration
	a_origin_needs_cal: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[2]) |-> (m_tdata[4:3] == ORG_NONE))
		else $error("origin reported outside calibration");

	// A held input beat blocks the slave side while the result is stalled
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted while the pipeline is full");

	// A beat that moves on with nothing behind it empties the input register
	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !accept) |=> !valid_s1)
		else $error("input register kept a beat that was already processed");

	// Every processed beat leaves a result in the output register
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("processed beat produced no result");

	// The unused event code never appears
	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'd3))
		else $error("illegal mode event code");

endmodule
`default_nettype wire

### sv/cmc_cfg_regs.sv
// Configuration registers of the calibration mode controller.
`default_nettype none
module cmc_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [15:0]   cfg_data,
	output cmc_pkg::cfg_t      cfg
);
	import cmc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks      <= DEBOUNCE_RST;
			cfg_q.timeout_ticks       <= TIMEOUT_RST;
			cfg_q.scan_interval_ticks <= SCAN_RST;
			cfg_q.button_present      <= BUTTON_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ticks      <= cfg_data;
				REG_TIMEOUT:  cfg_q.timeout_ticks       <= cfg_data;
				REG_SCAN:     cfg_q.scan_interval_ticks <= cfg_data[7:0];
				REG_BUTTON:   cfg_q.button_present      <= cfg_data[0];
				default:      cfg_q.button_present      <= cfg_q.button_present;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### sv/cmc_core.sv
// Mode state registers and the update for one item.
`default_nettype none
module cmc_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  cmc_pkg::item_t     item,
	input  cmc_pkg::cfg_t      cfg,
	output cmc_pkg::result_t   result
);
	import cmc_pkg::*;

	logic              mode_q, n_mode;
	logic [1:0]        origin_q, n_origin;
	logic [1:0]        pending_q, n_pending;
	logic [TIME_W-1:0] deb_start_q, n_deb_start;
	logic              deb_armed_q, n_deb_armed;
	logic [TIME_W-1:0] act_time_q, n_act_time;
	logic              act_valid_q, n_act_valid;
	logic [TIME_W-1:0] scan_time_q, n_scan_time;
	logic              scan_valid_q, n_scan_valid;

	logic [TIME_W-1:0] deb_gap, act_gap, scan_gap;
	logic              deb_done, act_expired, scan_early;
	logic              btn, pin, sw_cal;
	logic [1:0]        ev;

	// All time differences wrap modulo 2^32
	assign deb_gap     = item.now_time - deb_start_q;
	assign act_gap     = item.now_time - act_time_q;
	assign scan_gap    = item.now_time - scan_time_q;
	assign deb_done    = deb_gap >= {16'd0, cfg.debounce_ticks};
	assign act_expired = act_valid_q && (act_gap > {16'd0, cfg.timeout_ticks});
	assign scan_early  = scan_valid_q && (scan_gap < {24'd0, cfg.scan_interval_ticks});
	assign btn         = cfg.button_present;
	assign pin         = item.button_active;
	assign sw_cal      = mode_q && (origin_q == ORG_SW);

	always_comb begin
		n_mode       = mode_q;
		n_origin     = origin_q;
		n_pending    = pending_q;
		n_deb_start  = deb_start_q;
		n_deb_armed  = deb_armed_q;
		n_act_time   = act_time_q;
		n_act_valid  = act_valid_q;
		n_scan_time  = scan_time_q;
		n_scan_valid = scan_valid_q;
		ev           = EV_NONE;
		unique case (item.kind)
			KIND_TICK: begin
				if (pending_q == EV_ENTER || pending_q == EV_EXIT) begin
					// A queued event is reported and nothing is scanned
					ev          = pending_q;
					n_pending   = EV_NONE;
					n_deb_armed = 1'b0;
					n_deb_start = '0;
					if (pending_q == EV_ENTER) begin
						n_mode      = 1'b1;
						n_origin    = ORG_SW;
						n_act_time  = item.now_time;
						n_act_valid = 1'b1;
					end
				end else begin
					n_pending = EV_NONE;
					if (!(btn && scan_early)) begin
						if (btn) begin
							n_scan_time  = item.now_time;
							n_scan_valid = 1'b1;
						end
						if (!mode_q) begin
							if (btn) begin
								if (!pin) begin
									n_deb_armed = 1'b0;
									n_deb_start = '0;
								end else if (!deb_armed_q) begin
									n_deb_armed = 1'b1;
									n_deb_start = item.now_time;
								end else if (deb_done) begin
									n_mode      = 1'b1;
									n_origin    = ORG_HW;
									n_act_time  = '0;
									n_act_valid = 1'b0;
									n_deb_armed = 1'b0;
									n_deb_start = '0;
									ev          = EV_ENTER;
								end
							end
						end else if (origin_q == ORG_HW) begin
							if (!btn) begin
								n_mode      = 1'b0;
								n_origin    = ORG_NONE;
								n_act_time  = '0;
								n_act_valid = 1'b0;
								ev          = EV_EXIT;
							end else if (pin) begin
								n_deb_armed = 1'b0;
								n_deb_start = '0;
							end else if (!deb_armed_q) begin
								n_deb_armed = 1'b1;
								n_deb_start = item.now_time;
							end else if (deb_done) begin
								n_mode      = 1'b0;
								n_origin    = ORG_NONE;
								n_act_time  = '0;
								n_act_valid = 1'b0;
								n_deb_armed = 1'b0;
								n_deb_start = '0;
								ev          = EV_EXIT;
							end
						end else if (origin_q == ORG_SW) begin
							if (btn) begin
								n_deb_armed = 1'b0;
								n_deb_start = '0;
							end
							if (act_expired) begin
								n_mode      = 1'b0;
								n_origin    = ORG_NONE;
								n_act_time  = '0;
								n_act_valid = 1'b0;
								ev          = EV_EXIT;
							end
						end else begin
							// Calibration without an origin falls back silently
							n_mode      = 1'b0;
							n_origin    = ORG_NONE;
							n_act_time  = '0;
							n_act_valid = 1'b0;
						end
					end
				end
			end
			KIND_START: begin
				if (!mode_q) begin
					n_pending = EV_ENTER;
				end else if (sw_cal) begin
					n_act_time  = item.now_time;
					n_act_valid = 1'b1;
				end
			end
			KIND_STOP: begin
				if (pending_q == EV_ENTER) begin
					n_pending = EV_NONE;
				end else if (sw_cal) begin
					n_mode      = 1'b0;
					n_origin    = ORG_NONE;
					n_act_time  = '0;
					n_act_valid = 1'b0;
					n_pending   = EV_EXIT;
				end
			end
			KIND_KEEP: begin
				if (sw_cal) begin
					n_act_time  = item.now_time;
					n_act_valid = 1'b1;
				end
			end
			default: ev = EV_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			origin_q     <= ORG_NONE;
			pending_q    <= EV_NONE;
			deb_start_q  <= '0;
			deb_armed_q  <= 1'b0;
			act_time_q   <= '0;
			act_valid_q  <= 1'b0;
			scan_time_q  <= '0;
			scan_valid_q <= 1'b0;
		end else if (fire) begin
			mode_q       <= n_mode;
			origin_q     <= n_origin;
			pending_q    <= n_pending;
			deb_start_q  <= n_deb_start;
			deb_armed_q  <= n_deb_armed;
			act_time_q   <= n_act_time;
			act_valid_q  <= n_act_valid;
			scan_time_q  <= n_scan_time;
			scan_valid_q <= n_scan_valid;
		end
	end

	assign result.mode_event     = ev;
	assign result.in_calibration = n_mode;
	assign result.cal_origin     = n_mode ? n_origin : ORG_NONE;

endmodule
`default_nettype wire
